### sv/piecewise_cubic_bezier_engine_core_macros.svh
// Assertion macros for the Bezier engine
`ifndef PIECEWISE_CUBIC_BEZIER_ENGINE_CORE_MACROS_SVH
`define PIECEWISE_CUBIC_BEZIER_ENGINE_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define PCB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define PCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/pcbe_pkg.sv
// Shared types and constants for the Bezier engine
`timescale 1ns / 1ps
package pcbe_pkg;
  localparam int MaxSegments = 16;
  localparam int Depth = 3 * MaxSegments + 1;
  localparam int IdxW = $clog2(Depth);
  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdEdit = 2'd1;
  localparam logic [1:0] CmdEval = 2'd2;
  localparam logic RegSegmentCount = 1'b0;
  localparam logic RegClosedMode = 1'b1;

  // classified transaction handed from front to back
  typedef struct packed {
    logic [1:0]  op;       // CmdLoad / CmdEdit / CmdEval; load/edit only if ok
    logic        ok;
    logic [5:0]  k;
    logic        fix;      // edit has a neighbor fix
    logic        mirror;   // fix is a mirror, else a midpoint
    logic [5:0]  dst;
    logic [5:0]  ra;       // mirror: source; midpoint: far point
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  base;
    logic [15:0] u;
  } job_t;
endpackage

### sv/pcbe_front.sv
// Front end: accepts transactions, checks range and works out neighbor indices
`timescale 1ns / 1ps
module pcbe_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [5:0]  point_index,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [15:0] curve_param,
  input  logic [4:0]  n_act,
  input  logic        closed,
  output logic        q_valid,
  output pcbe_pkg::job_t q_job,
  input  logic        q_pop
);
  pcbe_pkg::job_t job;
  logic [6:0] m;
  logic [6:0] l;
  logic [1:0] r;
  logic [5:0] rem;
  logic [6:0] kp1, kp2, km1, km2;
  logic [20:0] s;
  logic [6:0] b;
  pcbe_pkg::job_t q0, q1;
  logic [1:0] cnt;
  logic push;

  // wrap-aware neighbor indices
  always_comb begin
    m = 7'(3 * n_act);
    l = m + 7'd1;
    // index mod 3 by compare and subtract
    rem = point_index;
    if (rem >= 6'd48) rem = rem - 6'd48;
    if (rem >= 6'd24) rem = rem - 6'd24;
    if (rem >= 6'd12) rem = rem - 6'd12;
    if (rem >= 6'd6) rem = rem - 6'd6;
    if (rem >= 6'd3) rem = rem - 6'd3;
    r = rem[1:0];
    kp1 = {1'b0, point_index} + 7'd1;
    kp2 = {1'b0, point_index} + 7'd2;
    km1 = {1'b0, point_index} + m;
    km2 = {1'b0, point_index} + m - 7'd1;
    if (kp1 >= l) kp1 = kp1 - l;
    if (kp2 >= l) kp2 = kp2 - l;
    if (km1 >= l) km1 = km1 - l;
    if (km2 >= l) km2 = km2 - l;
    s = 21'(n_act) * 21'(curve_param);
    b = 7'(3 * s[20:16]);
    if (b + 7'd3 >= 7'(pcbe_pkg::Depth)) b = 7'(pcbe_pkg::Depth - 4);
    job = '0;
    job.op = cmd;
    job.k = point_index;
    job.x = coord_x;
    job.y = coord_y;
    job.z = coord_z;
    job.base = b[5:0];
    job.u = s[15:0];
    job.ok = (cmd == pcbe_pkg::CmdEval) ||
             ((cmd == pcbe_pkg::CmdLoad || cmd == pcbe_pkg::CmdEdit) &&
              ({1'b0, point_index} <= m));
    job.mirror = (r == 2'd0);
    case (r)
      2'd0: begin
        job.dst = kp1[5:0];
        job.ra = km1[5:0];
        job.fix = closed || (point_index != 6'd0 && {1'b0, point_index} != m);
      end
      2'd1: begin
        job.dst = km1[5:0];
        job.ra = km2[5:0];
        job.fix = closed || (point_index != 6'd1);
      end
      default: begin
        job.dst = kp1[5:0];
        job.ra = kp2[5:0];
        job.fix = closed || ({1'b0, point_index} != m - 7'd1);
      end
    endcase
    if (cmd != pcbe_pkg::CmdEdit) job.fix = 1'b0;
  end

  // two-entry queue toward the back end
  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign q_job = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
    if (q_pop) begin
      q0 <= (push && cnt == 2'd1) ? job : q1;
      if (push && cnt == 2'd2) q1 <= job;
    end else if (push) begin
      if (cnt == 2'd0) q0 <= job;
      else q1 <= job;
    end
  end
endmodule

### sv/pcbe_back.sv
// Back end: control point memory, edit fix-up and de Casteljau evaluation
`timescale 1ns / 1ps
module pcbe_back (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  pcbe_pkg::job_t q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD0 = 7'b0000010, S_RD1 = 7'b0000100,
    S_FIX  = 7'b0001000, S_LERP = 7'b0010000, S_ADD = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;
  state_t state;
  pcbe_pkg::job_t job;
  logic [95:0] mem [pcbe_pkg::Depth];
  logic [95:0] rd;
  logic [5:0] ra_addr;
  logic [95:0] p [4];
  logic [2:0] rcnt;
  logic [2:0] lcnt;
  logic [1:0] ax;
  logic [31:0] pa, pb;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] prod_r;
  logic signed [31:0] base_r;
  logic signed [33:0] sum;
  logic signed [31:0] fixv [3];
  logic [31:0] res;
  logic [1:0] li;

  // read address sequencing
  always_comb begin
    case (state)
      S_RD0: ra_addr = (job.op == pcbe_pkg::CmdEval) ? job.base : job.k;
      default: ra_addr = (job.op == pcbe_pkg::CmdEval) ?
                 6'(job.base + 6'(rcnt)) : job.ra;
    endcase
  end

  always_ff @(posedge clk) rd <= mem[ra_addr[pcbe_pkg::IdxW-1:0]];

  // fix-up value per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [33:0] a2, bb;
      a2 = 34'(signed'(job.mirror ? p[0][32*i +: 32] : rd[32*i +: 32]));
      bb = 34'(signed'(job.mirror ? rd[32*i +: 32] : p[0][32*i +: 32]));
      if (job.mirror) begin
        a2 = (a2 <<< 1) - bb;
        if (a2 > 34'sd2147483647) fixv[i] = 32'h7fffffff;
        else if (a2 < -34'sd2147483648) fixv[i] = 32'h80000000;
        else fixv[i] = a2[31:0];
      end else begin
        a2 = a2 + bb;
        fixv[i] = a2[32:1];
      end
    end
    sum = 34'(base_r) + 34'(prod_r >>> 16);
  end

  // lerp operands: level pairs 0-1,1-2,2-3 then 0-1,1-2 then 0-1
  always_comb begin
    li = (lcnt == 3'd3 || lcnt == 3'd5) ? 2'd0 : (lcnt == 3'd4 ? 2'd1 : 2'(lcnt));
    pa = p[li][32*ax +: 32];
    pb = p[li + 2'd1][32*ax +: 32];
    diff = 33'(signed'(pb)) - 33'(signed'(pa));
    prod = 50'(diff) * 50'(signed'({1'b0, job.u})) + 50'sd32768;
    res = sum[31:0];
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          job <= q_job;
          rcnt <= 3'd0;
          if (!q_job.ok || q_job.op == pcbe_pkg::CmdLoad) begin
            state <= S_OUT;
            if (q_job.ok) mem[q_job.k[pcbe_pkg::IdxW-1:0]] <=
              {q_job.z, q_job.y, q_job.x};
          end else if (q_job.op == pcbe_pkg::CmdEdit) begin
            mem[q_job.k[pcbe_pkg::IdxW-1:0]] <= {q_job.z, q_job.y, q_job.x};
            state <= q_job.fix ? S_RD0 : S_OUT;
          end else begin
            state <= S_RD0;
          end
          ok <= q_job.ok;
          point_x <= '0;
          point_y <= '0;
          point_z <= '0;
        end
        S_RD0: begin
          rcnt <= 3'd1;
          state <= S_RD1;
        end
        S_RD1: begin
          p[2'(rcnt - 3'd1)] <= rd;
          if (job.op == pcbe_pkg::CmdEdit) begin
            state <= S_FIX;
          end else if (rcnt == 3'd4) begin
            lcnt <= 3'd0;
            ax <= 2'd0;
            state <= S_LERP;
          end else begin
            rcnt <= rcnt + 3'd1;
          end
        end
        S_FIX: begin
          // p[0] holds the first read; rd holds the second
          mem[job.dst[pcbe_pkg::IdxW-1:0]] <= {fixv[2], fixv[1], fixv[0]};
          state <= S_OUT;
        end
        S_LERP: begin
          prod_r <= prod;
          base_r <= signed'(pa);
          state <= S_ADD;
        end
        S_ADD: begin
          p[li][32*ax +: 32] <= res;
          state <= S_LERP;
          if (lcnt == 3'd5) begin
            case (ax)
              2'd0: point_x <= res;
              2'd1: point_y <= res;
              default: point_z <= res;
            endcase
            if (ax == 2'd2) state <= S_OUT;
            else begin
              ax <= ax + 2'd1;
              lcnt <= 3'd0;
            end
          end else begin
            lcnt <= lcnt + 3'd1;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/piecewise_cubic_bezier_engine_core.sv
// Top level of the piecewise cubic Bezier engine
`timescale 1ns / 1ps
`include "piecewise_cubic_bezier_engine_core_macros.svh"
// The engine holds 49 control points in one memory and serves load, edit and
// evaluate transactions one at a time behind a two-entry input queue. An edit
// with a neighbor fix makes two memory reads on the single read port, and an
// evaluation makes four point reads and then eighteen interpolations (six per
// axis) through one shared multiplier, each in a lerp state and an add state.
// The result register holds until taken.
module piecewise_cubic_bezier_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [5:0]  point_index,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [15:0] curve_param,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z
);
  logic [4:0] segment_count;
  logic closed_mode;
  logic [4:0] n_act;
  logic q_valid, q_pop;
  pcbe_pkg::job_t q_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= 5'd1;
      closed_mode <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == pcbe_pkg::RegSegmentCount) segment_count <= cfg_data;
      else closed_mode <= cfg_data[0];
    end
  end

  assign n_act = (segment_count == 5'd0) ? 5'd1 :
                 (segment_count > 5'(pcbe_pkg::MaxSegments)) ?
                 5'(pcbe_pkg::MaxSegments) : segment_count;

  pcbe_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .point_index, .coord_x, .coord_y,
    .coord_z, .curve_param, .n_act, .closed(closed_mode), .q_valid, .q_job, .q_pop
  );

  pcbe_back u_back (
    .clk, .rst, .q_valid, .q_job, .q_pop, .out_valid, .out_stall, .ok,
    .point_x, .point_y, .point_z
  );

  `PCB_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid && $stable(ok))
  `PCB_ASSERT_IMP(a_no_pop_busy, clk, rst, out_valid, !q_pop)
  `PCB_ASSERT_IMP(a_rej_zero, clk, rst, out_valid && !ok, point_x == 32'd0)
endmodule
